// File: hw/rtl/mbe_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package mbe_pkg;

  // Field and word widths fixed by the interface.
  localparam int WORD_W  = 32;
  localparam int STEP_W  = 31;
  localparam int COORD_W = 10;
  localparam int ITER_W  = 16;
  localparam int WIDE_W  = 66;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes (word address).
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_RE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_IM = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_RE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STEP_IM   = 3'd4;

  // Register reset values.
  localparam logic [ITER_W-1:0]        RST_MAX_ITER = 16'd255;
  localparam logic signed [WORD_W-1:0] RST_ORIGIN   = -32'sd536870912;
  localparam logic [STEP_W-1:0]        RST_STEP     = 31'd1048576;

  // One pixel request.
  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } in_item_t;

  // One escape-time result.
  typedef struct packed {
    logic [ITER_W-1:0]  iteration_count;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
  } out_item_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [ITER_W-1:0]        max_iterations;
    logic signed [WORD_W-1:0] origin_re;
    logic signed [WORD_W-1:0] origin_im;
    logic [STEP_W-1:0]        step_re;
    logic [STEP_W-1:0]        step_im;
  } cfg_t;

  // A classified pixel waiting for iteration.
  typedef struct packed {
    logic signed [WORD_W-1:0] cr;
    logic signed [WORD_W-1:0] ci;
    logic [ITER_W-1:0]        limit;
    logic [COORD_W-1:0]       column;
    logic [COORD_W-1:0]       row;
  } job_t;

  // Queue status seen by both parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    logic signed [WORD_W-1:0] res;
    hi = WIDE_W'(64'sh000000007FFFFFFF);
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v < lo) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = v[WORD_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mbe_front.sv
// Front part: takes a pixel request, maps it to the point c and clamps the limit.
// Depends on mbe_pkg; feeds mbe_queue.
`default_nettype none

module mbe_front
  import mbe_pkg::*;
#(
  parameter int IMAGE_SIZE = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire in_item_t in_item,
  output logic          busy,
  input  wire cfg_t     cfg,
  input  wire q_flags_t q_flags,
  output logic          push,
  output job_t          push_job
);

  localparam logic [16:0] COORD_MAX = 17'(IMAGE_SIZE - 1);
  localparam logic [ITER_W-1:0] CNT_MAX = (COUNT_BITS >= ITER_W) ? {ITER_W{1'b1}} :
                                          ITER_W'((33'd1 << COUNT_BITS) - 33'd1);

  logic     fs_valid_r, fs_valid_nxt;
  in_item_t fs_item_r;

  logic [COORD_W-1:0]      col_cl, row_cl;
  logic [STEP_W+COORD_W-1:0] prod_re, prod_im;
  logic signed [WIDE_W-1:0]  sum_re, sum_im;

  // One request is held here until the queue has room.
  assign busy = fs_valid_r;
  assign push = fs_valid_r && !q_flags.full;

  always_comb begin
    fs_valid_nxt = fs_valid_r;
    if (push) begin
      fs_valid_nxt = 1'b0;
    end
    if (start && !busy) begin
      fs_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_valid_r <= 1'b0;
    end else begin
      fs_valid_r <= fs_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      fs_item_r <= in_item;
    end
  end

  // Coordinates past the image edge map to the last pixel.
  assign col_cl = ({7'b0, fs_item_r.column} > COORD_MAX) ? COORD_MAX[COORD_W-1:0]
                                                         : fs_item_r.column;
  assign row_cl = ({7'b0, fs_item_r.row} > COORD_MAX) ? COORD_MAX[COORD_W-1:0]
                                                      : fs_item_r.row;

  // c = origin + step * coordinate, saturated to one word.
  assign prod_re = {{COORD_W{1'b0}}, cfg.step_re} * {{STEP_W{1'b0}}, col_cl};
  assign prod_im = {{COORD_W{1'b0}}, cfg.step_im} * {{STEP_W{1'b0}}, row_cl};
  assign sum_re  = $signed({{(WIDE_W-STEP_W-COORD_W){1'b0}}, prod_re})
                 + WIDE_W'(cfg.origin_re);
  assign sum_im  = $signed({{(WIDE_W-STEP_W-COORD_W){1'b0}}, prod_im})
                 + WIDE_W'(cfg.origin_im);

  always_comb begin
    push_job.cr     = sat_word(sum_re);
    push_job.ci     = sat_word(sum_im);
    push_job.limit  = (cfg.max_iterations < CNT_MAX) ? cfg.max_iterations : CNT_MAX;
    push_job.column = fs_item_r.column;
    push_job.row    = fs_item_r.row;
  end

endmodule

`default_nettype wire

// File: hw/rtl/mbe_queue.sv
// Short queue of classified pixels between the front and back parts.
// Depends on mbe_pkg.
`default_nettype none

module mbe_queue
  import mbe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      pop_job,
  output q_flags_t  q_flags
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_flags.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_flags.empty = (cnt_r == '0);
  assign pop_job       = mem[rd_ptr_r];

  // Pointer and fill-count update; wraps at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mbe_core.sv
// Back part: iterates z = z*z + c for one pixel at a time and emits the count.
// Depends on mbe_pkg; takes its work from mbe_queue.
`default_nettype none

module mbe_core
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_flags_t q_flags,
  input  wire job_t     pop_job,
  output logic          pop,
  output logic          out_valid,
  output out_item_t     out_item
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  localparam logic signed [WIDE_W-1:0] ESC_BOUND = WIDE_W'(4) <<< FRAC_BITS;

  logic [1:0] state_r, state_nxt;
  job_t       job_r;

  logic signed [WORD_W-1:0] zr_r, zi_r, zr_nxt, zi_nxt;
  logic signed [WORD_W-1:0] rr_r, ii_r, ri2_r;
  logic [ITER_W-1:0]        cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r;

  logic signed [2*WORD_W-1:0] p_rr, p_ii, p_ri;
  logic signed [WIDE_W-1:0]   mag, new_re, new_im;
  logic                       done;

  assign pop       = (state_r == ST_IDLE) && !q_flags.empty;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Multiply stage: squares and cross term, floored and saturated.
  assign p_rr = zr_r * zr_r;
  assign p_ii = zi_r * zi_r;
  assign p_ri = zr_r * zi_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      rr_r  <= sat_word(WIDE_W'(p_rr >>> FRAC_BITS));
      ii_r  <= sat_word(WIDE_W'(p_ii >>> FRAC_BITS));
      ri2_r <= sat_word(WIDE_W'(p_ri >>> (FRAC_BITS - 1)));
    end
  end

  // Update stage: escape test and the next z.
  assign mag    = WIDE_W'(rr_r) + WIDE_W'(ii_r);
  assign new_re = WIDE_W'(rr_r) - WIDE_W'(ii_r) + WIDE_W'(job_r.cr);
  assign new_im = WIDE_W'(ri2_r) + WIDE_W'(job_r.ci);
  assign done   = (mag >= ESC_BOUND) || (cnt_r >= job_r.limit);

  always_comb begin
    state_nxt     = state_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          zr_nxt    = '0;
          zi_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          zr_nxt    = sat_word(new_re);
          zi_nxt    = sat_word(new_im);
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zr_r  <= zr_nxt;
    zi_r  <= zi_nxt;
    cnt_r <= cnt_nxt;
    if (pop) begin
      job_r <= pop_job;
    end
    if (state_r == ST_UPD && done) begin
      out_item_r.iteration_count <= cnt_r;
      out_item_r.out_column      <= job_r.column;
      out_item_r.out_row         <= job_r.row;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time block: register file and part wiring.
// Depends on mbe_pkg, mbe_front, mbe_queue and mbe_core.
//
//   Channel   Signals                                  Direction
//   request   start, busy, in_item(column,row)         in, accepted when start && !busy
//   result    out_valid, out_item(count,column,row)    out, one-cycle strobe
//   config    psel penable pwrite paddr pwdata prdata  APB, pready tied high
//
// A pixel is registered in the front stage, then waits in a two-entry queue.
// Each iteration of the loop runs a multiply step, then an update step, until the
// pixel escapes or reaches its iteration limit.
// busy is high for one cycle after each request, and longer while the queue is full.
// rst_n is synchronous; there is no clearing pass. Results cannot be stalled.
`default_nettype none

module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int IMAGE_SIZE = 1024,
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire in_item_t    in_item,
  output logic             busy,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t     cfg_r;
  q_flags_t q_flags;
  job_t     push_job, pop_job;
  logic     push, pop;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iterations <= RST_MAX_ITER;
      cfg_r.origin_re      <= RST_ORIGIN;
      cfg_r.origin_im      <= RST_ORIGIN;
      cfg_r.step_re        <= RST_STEP;
      cfg_r.step_im        <= RST_STEP;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_MAX_ITER:  cfg_r.max_iterations <= pwdata[ITER_W-1:0];
        REG_ORIGIN_RE: cfg_r.origin_re      <= $signed(pwdata);
        REG_ORIGIN_IM: cfg_r.origin_im      <= $signed(pwdata);
        REG_STEP_RE:   cfg_r.step_re        <= pwdata[STEP_W-1:0];
        REG_STEP_IM:   cfg_r.step_im        <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      REG_MAX_ITER:  prdata = {16'b0, cfg_r.max_iterations};
      REG_ORIGIN_RE: prdata = cfg_r.origin_re;
      REG_ORIGIN_IM: prdata = cfg_r.origin_im;
      REG_STEP_RE:   prdata = {1'b0, cfg_r.step_re};
      REG_STEP_IM:   prdata = {1'b0, cfg_r.step_im};
      default:       prdata = '0;
    endcase
  end

  mbe_front #(
    .IMAGE_SIZE (IMAGE_SIZE),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .cfg      (cfg_r),
    .q_flags  (q_flags),
    .push     (push),
    .push_job (push_job)
  );

  mbe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_flags  (q_flags)
  );

  mbe_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_flags   (q_flags),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
